/* sv/crd_pkg.sv */
// ----------------------------------------------------------------------------
// crd_pkg: shared types and constants for the character raster draw engine
// Operation codes, command record passed from front end to back end.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int unsigned MaxWidthDef  = 128;
  localparam int unsigned MaxHeightDef = 128;

  localparam int unsigned CoordW = 12;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned CharW  = 8;
  localparam int unsigned RadW   = 12;
  localparam int unsigned RegW   = 8;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [3:0] {
    OP_GET    = 4'd0,
    OP_SET    = 4'd1,
    OP_FILL   = 4'd2,
    OP_HLINE  = 4'd3,
    OP_VLINE  = 4'd4,
    OP_BOX    = 4'd5,
    OP_FBOX   = 4'd6,
    OP_DISK   = 4'd7,
    OP_COPY   = 4'd8,
    OP_KCOPY  = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    REG_W0  = 3'd0,
    REG_H0  = 3'd1,
    REG_BG0 = 3'd2,
    REG_W1  = 3'd3,
    REG_H1  = 3'd4,
    REG_BG1 = 3'd5
  } reg_e;

  // Command record as it travels through the queue.
  typedef struct packed {
    logic [3:0]               op;
    logic                     sel;
    logic signed [CoordW-1:0] xa;
    logic signed [CoordW-1:0] ya;
    logic signed [CoordW-1:0] xb;
    logic signed [CoordW-1:0] yb;
    logic [SizeW-1:0]         cw;
    logic [SizeW-1:0]         ch;
    logic [CharW-1:0]         chr;
    logic [RadW-1:0]          rad;
  } cmd_t;

endpackage

/* sv/crd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// crd_cmd_fifo: two-entry command queue
// Decouples the command front end from the drawing back end.
// ----------------------------------------------------------------------------
module crd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_stall_o,
  input  crd_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_stall_i,
  output crd_pkg::cmd_t rd_data_o
);
  import crd_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_valid_o && !rd_stall_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("queue count not advanced on push");

endmodule

/* sv/crd_back.sv */
// ----------------------------------------------------------------------------
// crd_back: drawing back end
// Sequencer that walks each command's window, one memory access a cycle.
// ----------------------------------------------------------------------------
module crd_back #(
  parameter int unsigned MAX_WIDTH  = crd_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = crd_pkg::MaxHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_stall_o,
  input  crd_pkg::cmd_t              cmd_i,
  input  logic [crd_pkg::RegW-1:0]   width0_i,
  input  logic [crd_pkg::RegW-1:0]   height0_i,
  input  logic [crd_pkg::RegW-1:0]   bg0_i,
  input  logic [crd_pkg::RegW-1:0]   width1_i,
  input  logic [crd_pkg::RegW-1:0]   height1_i,
  input  logic [crd_pkg::RegW-1:0]   bg1_i,
  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output logic [crd_pkg::CharW-1:0]  read_value_o,
  output logic                       out_of_bounds_o,
  output logic                       source_clamped_o
);
  import crd_pkg::*;

  localparam int unsigned XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW    = 1 + YW + XW;
  localparam int unsigned Depth = 2 ** AW;
  // internal signed coordinate width: holds 16*coord +- radius sums
  localparam int unsigned SW    = 20;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_PAINT, ST_CRD, ST_CWR, ST_GETW, ST_DONE
  } st_e;

  st_e st_q, st_d;

  logic [CharW-1:0] mem [Depth];
  logic [CharW-1:0] rdata_q;

  cmd_t cmd_q, cmd_d;
  logic [2:0] rect_q, rect_d;       // current sub rectangle of an empty box
  logic signed [SW-1:0] x1_q, x1_d, x2_q, x2_d, y1_q, y1_d, y2_q, y2_d;
  logic signed [SW-1:0] x_q, x_d, y_q, y_d;
  logic [CharW-1:0] rv_q, rv_d;
  logic oob_q, oob_d, clp_q, clp_d;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [CharW-1:0] wdata;

  // surface geometry
  logic              s, t;
  logic signed [SW-1:0] ws, hs, wt, ht;
  logic [CharW-1:0]  bgs, bgt;

  function automatic logic signed [SW-1:0] fix_size(input logic [RegW-1:0] v,
                                                    input int unsigned mx);
    logic signed [SW-1:0] r;
    begin
      r = SW'(v);
      if (r < 1) r = 1;
      if (r > SW'(mx)) r = SW'(mx);
      return r;
    end
  endfunction

  function automatic logic signed [SW-1:0] win_bound(input logic signed [SW-1:0] n,
                                                     input logic signed [SW-1:0] hi);
    logic signed [SW-1:0] v;
    begin
      v = (n < 0) ? '0 : (n >>> 4);
      return (v > hi) ? hi : v;
    end
  endfunction

  assign s   = cmd_q.sel;
  assign t   = ~cmd_q.sel;
  assign ws  = s ? fix_size(width1_i, MAX_WIDTH)   : fix_size(width0_i, MAX_WIDTH);
  assign hs  = s ? fix_size(height1_i, MAX_HEIGHT) : fix_size(height0_i, MAX_HEIGHT);
  assign wt  = t ? fix_size(width1_i, MAX_WIDTH)   : fix_size(width0_i, MAX_WIDTH);
  assign ht  = t ? fix_size(height1_i, MAX_HEIGHT) : fix_size(height0_i, MAX_HEIGHT);
  assign bgs = s ? bg1_i : bg0_i;
  assign bgt = t ? bg1_i : bg0_i;

  assign cmd_stall_o      = (st_q != ST_IDLE);
  assign res_valid_o      = (st_q == ST_DONE);
  assign read_value_o     = rv_q;
  assign out_of_bounds_o  = oob_q;
  assign source_clamped_o = clp_q;

  // coordinate extensions of the command
  logic signed [SW-1:0] xa, ya, xb, yb, cwx, chx;
  assign xa  = SW'($signed(cmd_q.xa));
  assign ya  = SW'($signed(cmd_q.ya));
  assign xb  = SW'($signed(cmd_q.xb));
  assign yb  = SW'($signed(cmd_q.yb));
  assign cwx = SW'({1'b0, cmd_q.cw});
  assign chx = SW'({1'b0, cmd_q.ch});

  // disk test, the squares are combinational at these widths
  logic signed [SW-1:0] ddx, ddy;
  logic [2*SW-1:0]      dsq;
  logic [2*RadW-1:0]    rr;
  logic                 in_disk;
  assign ddx = x_q - xa;
  assign ddy = y_q - ya;
  assign dsq = (2*SW)'(ddx * ddx) + (2*SW)'(ddy * ddy);
  assign rr  = cmd_q.rad * cmd_q.rad;
  assign in_disk = ({dsq, 8'd0} <= (2*SW+8)'(rr));

  // copy coordinates
  logic signed [SW-1:0] tx, ty;
  logic                 t_in;
  assign tx   = xb + (x_q - x1_q);
  assign ty   = yb + (y_q - y1_q);
  assign t_in = (tx >= 0) && (ty >= 0) && (tx < wt) && (ty < ht);

  function automatic logic [AW-1:0] mk_addr(input logic sf, input logic signed [SW-1:0] xx,
                                            input logic signed [SW-1:0] yy);
    return {sf, yy[YW-1:0], xx[XW-1:0]};
  endfunction

  logic is_get_in;
  assign is_get_in = (xa >= 0) && (ya >= 0) && (xa < ws) && (ya < hs);

  logic signed [SW-1:0] bx1, bx2, by1, by2;
  always_comb begin
    // sub rectangles of the empty box
    bx1 = xa; bx2 = xa; by1 = ya; by2 = yb;
    case (rect_q)
      3'd1: begin bx1 = xb; bx2 = xb; end
      3'd2: begin bx1 = SW'(xa + 1); bx2 = SW'(xb - 1); by2 = ya; end
      3'd3: begin bx1 = SW'(xa + 1); bx2 = SW'(xb - 1); by1 = yb; by2 = yb; end
      default: ;
    endcase
  end

  logic signed [SW-1:0] cex, cey;
  assign cex = SW'(xa + cwx - 1);
  assign cey = SW'(ya + chx - 1);

  logic signed [SW-1:0] wsm1, hsm1;
  assign wsm1 = SW'(ws - 1);
  assign hsm1 = SW'(hs - 1);

  logic last_x, last_y;
  assign last_x = (x_q >= x2_q);
  assign last_y = (y_q >= y2_q);

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; rect_d = rect_q;
    x1_d = x1_q; x2_d = x2_q; y1_d = y1_q; y2_d = y2_q;
    x_d = x_q; y_d = y_q; rv_d = rv_q; oob_d = oob_q; clp_d = clp_q;
    we = 1'b0; waddr = mk_addr(s, x_q, y_q); wdata = cmd_q.chr;
    raddr = mk_addr(s, x_q, y_q);
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i; rect_d = 3'd0;
          rv_d = '0; oob_d = 1'b0; clp_d = 1'b0;
          st_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        x1_d = '0; x2_d = '1; y1_d = '0; y2_d = '1;
        st_d = ST_PAINT;
        case (cmd_q.op)
          OP_GET: begin
            raddr = mk_addr(s, xa, ya);
            if (is_get_in) st_d = ST_GETW;
            else begin rv_d = bgs; oob_d = 1'b1; st_d = ST_DONE; end
          end
          OP_SET: begin
            if (is_get_in) begin
              we = 1'b1; waddr = mk_addr(s, xa, ya);
            end else oob_d = 1'b1;
            st_d = ST_DONE;
          end
          OP_FILL: begin x2_d = wsm1; y2_d = hsm1; end
          OP_HLINE: begin x1_d = xa; x2_d = xb; y1_d = ya; y2_d = ya; end
          OP_VLINE: begin x1_d = xa; x2_d = xa; y1_d = ya; y2_d = yb; end
          OP_BOX: begin x1_d = bx1; x2_d = bx2; y1_d = by1; y2_d = by2; end
          OP_FBOX: begin x1_d = xa; x2_d = xb; y1_d = ya; y2_d = yb; end
          OP_DISK: begin
            x1_d = win_bound(SW'(16*xa - SW'(cmd_q.rad) - 32), wsm1);
            x2_d = win_bound(SW'(16*xa + SW'(cmd_q.rad) + 32), wsm1);
            y1_d = win_bound(SW'(16*ya - SW'(cmd_q.rad) - 32), hsm1);
            y2_d = win_bound(SW'(16*ya + SW'(cmd_q.rad) + 32), hsm1);
          end
          OP_COPY, OP_KCOPY: begin
            x1_d = (xa < 0) ? '0 : ((xa > wsm1) ? wsm1 : xa);
            y1_d = (ya < 0) ? '0 : ((ya > hsm1) ? hsm1 : ya);
            x2_d = (cex < 0) ? '0 : ((cex > wsm1) ? wsm1 : cex);
            y2_d = (cey < 0) ? '0 : ((cey > hsm1) ? hsm1 : cey);
            clp_d = (xa < 0) || (xa > wsm1) || (ya < 0) || (ya > hsm1) ||
                    (cex < 0) || (cex > wsm1) || (cey < 0) || (cey > hsm1);
            st_d = ST_CRD;
          end
          default: st_d = ST_DONE;
        endcase
        // clip to surface for drawing commands
        if (cmd_q.op inside {OP_HLINE, OP_VLINE, OP_BOX, OP_FBOX}) begin
          if (x1_d < 0) x1_d = '0;
          if (y1_d < 0) y1_d = '0;
          if (x2_d > wsm1) x2_d = wsm1;
          if (y2_d > hsm1) y2_d = hsm1;
        end
        x_d = x1_d; y_d = y1_d;
        if (st_d == ST_PAINT || st_d == ST_CRD) begin
          if (x1_d > x2_d || y1_d > y2_d) st_d = ST_DONE;
        end
        if (st_d == ST_DONE && cmd_q.op == OP_BOX && rect_q != 3'd3) begin
          rect_d = rect_q + 3'd1; st_d = ST_SETUP;
        end
      end
      ST_PAINT: begin
        we = (cmd_q.op != OP_DISK) || in_disk;
        waddr = mk_addr(s, x_q, y_q);
        if (!last_x) x_d = SW'(x_q + 1);
        else begin
          x_d = x1_q;
          if (!last_y) y_d = SW'(y_q + 1);
          else if (cmd_q.op == OP_BOX && rect_q != 3'd3) begin
            rect_d = rect_q + 3'd1; st_d = ST_SETUP;
          end else st_d = ST_DONE;
        end
      end
      ST_CRD: begin
        raddr = mk_addr(s, x_q, y_q);
        st_d = ST_CWR;
      end
      ST_CWR: begin
        if (t_in) begin
          we = 1'b1;
          waddr = mk_addr(t, tx, ty);
          wdata = (cmd_q.op == OP_KCOPY && rdata_q == bgs) ? bgt : rdata_q;
        end else oob_d = 1'b1;
        st_d = ST_CRD;
        if (!last_x) x_d = SW'(x_q + 1);
        else begin
          x_d = x1_q;
          if (!last_y) y_d = SW'(y_q + 1);
          else st_d = ST_DONE;
        end
      end
      ST_GETW: begin
        rv_d = rdata_q; st_d = ST_DONE;
      end
      ST_DONE: begin
        if (!res_stall_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; rect_q <= rect_d;
    x1_q <= x1_d; x2_q <= x2_d; y1_q <= y1_d; y2_q <= y2_d;
    x_q <= x_d; y_q <= y_d;
    rv_q <= rv_d; oob_q <= oob_d; clp_q <= clp_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && res_stall_i) |=> (st_q == ST_DONE))
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_GETW) |=> (st_q == ST_DONE))
    else $error("get did not complete");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CWR) |-> $past(st_q == ST_CRD))
    else $error("copy write without read");

endmodule

/* sv/char_raster_draw_engine_unit.sv */
// ----------------------------------------------------------------------------
// char_raster_draw_engine_unit: two-surface character blitter
// Command queue in front of a drawing sequencer over one surface memory.
// ----------------------------------------------------------------------------
// A command is set up and then visits each character in its window on the
// surface memory, a copy reading and then writing each character. Up to two
// commands queue ahead of the sequencer. Surface memory is not cleared at
// reset; software fills a surface before reading it.
module char_raster_draw_engine_unit #(
  parameter int unsigned MAX_WIDTH  = crd_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = crd_pkg::MaxHeightDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [crd_pkg::RegIdxW-1:0]      cfg_index_i,
  input  logic [crd_pkg::RegW-1:0]         cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [3:0]                       operation_i,
  input  logic                             surface_select_i,
  input  logic signed [crd_pkg::CoordW-1:0] x_a_i,
  input  logic signed [crd_pkg::CoordW-1:0] y_a_i,
  input  logic signed [crd_pkg::CoordW-1:0] x_b_i,
  input  logic signed [crd_pkg::CoordW-1:0] y_b_i,
  input  logic [crd_pkg::SizeW-1:0]        copy_width_i,
  input  logic [crd_pkg::SizeW-1:0]        copy_height_i,
  input  logic [crd_pkg::CharW-1:0]        char_value_i,
  input  logic [crd_pkg::RadW-1:0]         radius_q4_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [crd_pkg::CharW-1:0]        read_value_o,
  output logic                             out_of_bounds_o,
  output logic                             source_clamped_o
);
  import crd_pkg::*;

  logic [RegW-1:0] w0_q, h0_q, bg0_q, w1_q, h1_q, bg1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q <= 8'd128; h0_q <= 8'd128; bg0_q <= 8'd32;
      w1_q <= 8'd128; h1_q <= 8'd128; bg1_q <= 8'd32;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_W0:  w0_q  <= cfg_data_i;
        REG_H0:  h0_q  <= cfg_data_i;
        REG_BG0: bg0_q <= cfg_data_i;
        REG_W1:  w1_q  <= cfg_data_i;
        REG_H1:  h1_q  <= cfg_data_i;
        REG_BG1: bg1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_stall;

  always_comb begin
    in_cmd.op  = operation_i;
    in_cmd.sel = surface_select_i;
    in_cmd.xa  = x_a_i;
    in_cmd.ya  = y_a_i;
    in_cmd.xb  = x_b_i;
    in_cmd.yb  = y_b_i;
    in_cmd.cw  = copy_width_i;
    in_cmd.ch  = copy_height_i;
    in_cmd.chr = char_value_i;
    in_cmd.rad = radius_q4_i;
  end

  crd_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_stall_o (in_stall_o),
    .wr_data_i  (in_cmd),
    .rd_valid_o (q_valid),
    .rd_stall_i (q_stall),
    .rd_data_o  (q_cmd)
  );

  crd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_stall_o      (q_stall),
    .cmd_i            (q_cmd),
    .width0_i         (w0_q),
    .height0_i        (h0_q),
    .bg0_i            (bg0_q),
    .width1_i         (w1_q),
    .height1_i        (h1_q),
    .bg1_i            (bg1_q),
    .res_valid_o      (out_valid_o),
    .res_stall_i      (out_stall_i),
    .read_value_o     (read_value_o),
    .out_of_bounds_o  (out_of_bounds_o),
    .source_clamped_o (source_clamped_o)
  );

endmodule
